// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sorter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed: %m");

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition: %m");

`endif

// ===== rtl/ssrt_pkg.sv =====
// Types and constants of the systolic insertion sorter.
package ssrt_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 31;
    localparam int CNT_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERT,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic               vld;
        logic [VALUE_W-1:0] value;
    } link_t;

    typedef struct packed {
        logic               full;
        logic [VALUE_W-1:0] value;
    } slot_t;

endpackage

// ===== rtl/ssrt_cell.sv =====
// One compare-and-pass cell of the sorting chain.
`include "assert_macros.svh"

module ssrt_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  ssrt_pkg::link_t link_in,
    output ssrt_pkg::link_t link_out,
    input  logic           shift,
    input  ssrt_pkg::slot_t slot_in,
    output ssrt_pkg::slot_t slot_out
);
    import ssrt_pkg::*;

    logic               full_reg, full_next;
    logic [VALUE_W-1:0] held_reg, held_next;
    logic               vld_reg, vld_next;
    logic [VALUE_W-1:0] pass_reg, pass_next;

    always_comb begin
        full_next = full_reg;
        held_next = held_reg;
        vld_next  = 1'b0;
        pass_next = pass_reg;
        if (shift) begin
            full_next = slot_in.full;
            held_next = slot_in.value;
        end else if (link_in.vld) begin
            if (!full_reg) begin
                full_next = 1'b1;
                held_next = link_in.value;
            end else if (link_in.value > held_reg) begin
                held_next = link_in.value;
                pass_next = held_reg;
                vld_next  = 1'b1;
            end else begin
                pass_next = link_in.value;
                vld_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            vld_reg  <= 1'b0;
        end else begin
            full_reg <= full_next;
            vld_reg  <= vld_next;
        end
        held_reg <= held_next;
        pass_reg <= pass_next;
    end

    assign link_out.vld   = vld_reg;
    assign link_out.value = pass_reg;
    assign slot_out.full  = full_reg;
    assign slot_out.value = held_reg;

    `ASSERT_NEVER(no_shift_during_push, aclk, aresetn, shift && link_in.vld)
    `ASSERT_IMPL(empty_cell_passes_nothing, aclk, aresetn, !full_reg |-> !vld_reg)

endmodule

// ===== rtl/systolic_insertion_sorter.sv =====
// Top level of the systolic insertion sorter: cell chain, flush control, output stage.
// Inserts are taken one per cycle while s_ready is high; each enters cell 0 and
// ripples down the chain of CAPACITY cells one cell per cycle, so back-to-back inserts
// never wait. A flush first holds s_ready low until the entry register and every pass
// register in the chain are empty, then shifts the whole chain toward cell 0, one slot
// per cycle that the output register can take, giving CAPACITY beats from largest to
// smallest with m_last on the final one. The shift clears the store as it goes, and
// inserts are taken again as soon as the last beat is loaded into the output register.
`include "assert_macros.svh"

module systolic_insertion_sorter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [ssrt_pkg::VALUE_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ssrt_pkg::VALUE_W-1:0] m_value_res,
    output logic                         m_empty_res,
    output logic                         m_last
);
    import ssrt_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    link_t              entry_reg, entry_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               empty_reg, empty_next;
    logic               last_reg, last_next;

    link_t link [CAPACITY+1];
    slot_t slot [CAPACITY+1];
    logic  shift;
    logic  busy;
    logic  out_load;
    logic  in_accept;
    logic  final_beat;

    assign link[0]        = entry_reg;
    assign slot[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        ssrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .shift    (shift),
            .slot_in  (slot[i+1]),
            .slot_out (slot[i])
        );
    end

    always_comb begin
        busy = 1'b0;
        for (int i = 0; i <= CAPACITY; i++) begin
            busy = busy | link[i].vld;
        end
    end

    assign s_ready    = (state_reg == ST_INSERT);
    assign in_accept  = s_valid && s_ready;
    assign out_load   = !m_valid_reg || m_ready;
    assign final_beat = (cnt_reg == CNT_W'(CAPACITY - 1));

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        entry_next   = '0;
        m_valid_next = m_valid_reg && !m_ready;
        value_next   = value_reg;
        empty_next   = empty_reg;
        last_next    = last_reg;
        shift        = 1'b0;
        case (state_reg)
            ST_INSERT: begin
                if (in_accept) begin
                    if (s_op == OP_FLUSH) begin
                        state_next = ST_DRAIN;
                    end else begin
                        entry_next.vld   = 1'b1;
                        entry_next.value = s_value;
                    end
                end
            end
            ST_DRAIN: begin
                if (!busy) begin
                    state_next = ST_FLUSH;
                    cnt_next   = '0;
                end
            end
            ST_FLUSH: begin
                if (out_load) begin
                    shift        = 1'b1;
                    m_valid_next = 1'b1;
                    value_next   = slot[0].full ? slot[0].value : '0;
                    empty_next   = !slot[0].full;
                    last_next    = final_beat;
                    if (final_beat) begin
                        state_next = ST_INSERT;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_INSERT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INSERT;
            cnt_reg       <= '0;
            entry_reg.vld <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            entry_reg.vld <= entry_next.vld;
            m_valid_reg   <= m_valid_next;
        end
        entry_reg.value <= entry_next.value;
        value_reg       <= value_next;
        empty_reg       <= empty_next;
        last_reg        <= last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_value_res = value_reg;
    assign m_empty_res = empty_reg;
    assign m_last      = last_reg;

    `ASSERT_IMPL(flush_on_settled_chain, aclk, aresetn, (state_reg == ST_FLUSH) |-> !busy)
    `ASSERT_IMPL(count_idle_outside_flush, aclk, aresetn, (state_reg == ST_INSERT) |-> (cnt_reg == '0))

endmodule

// ===== tb/sv/systolic_insertion_sorter_tb.sv =====
// Testbench for the systolic insertion sorter: directed table, random insert/flush runs, scoreboard.
`timescale 1ns / 1ps

module systolic_insertion_sorter_tb;
    import ssrt_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = CAPACITY + 16;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               empty;
        logic               last;
    } rank_beat_t;

    typedef struct {
        op_t                op;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        logic [VALUE_W-1:0] top_value;
        logic               top_empty;
    } dir_row_t;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_op    = OP_INSERT;
    logic [VALUE_W-1:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [VALUE_W-1:0] m_value_res;
    logic               m_empty_res;
    logic               m_last;

    logic [VALUE_W-1:0] sorted_val [CAPACITY];
    logic               sorted_full[CAPACITY];
    rank_beat_t         pending_ranks[$];

    int err_count      = 0;
    int beats_checked  = 0;
    int insert_count   = 0;
    int flush_count    = 0;
    int overfill_count = 0;
    int fill_count     = 0;
    int burst_left     = 0;

    rx_mode_t rx_mode = RX_FREE;
    int       rx_left = 0;

    dir_row_t dir_rows[] = '{
        '{OP_FLUSH,  31'd0,          1'b1, 31'd0,          1'b1},
        '{OP_INSERT, 31'h7FFFFFFF,   1'b0, 31'd0,          1'b0},
        '{OP_INSERT, 31'd0,          1'b0, 31'd0,          1'b0},
        '{OP_FLUSH,  31'h7FFFFFFF,   1'b1, 31'h7FFFFFFF,   1'b0},
        '{OP_FLUSH,  31'd0,          1'b1, 31'd0,          1'b1},
        '{OP_INSERT, 31'd5,          1'b0, 31'd0,          1'b0},
        '{OP_INSERT, 31'd5,          1'b0, 31'd0,          1'b0},
        '{OP_INSERT, 31'd5,          1'b0, 31'd0,          1'b0},
        '{OP_INSERT, 31'h2AAAAAAA,   1'b0, 31'd0,          1'b0},
        '{OP_INSERT, 31'h55555555,   1'b0, 31'd0,          1'b0},
        '{OP_INSERT, 31'd0,          1'b0, 31'd0,          1'b0},
        '{OP_FLUSH,  31'h1234567,    1'b1, 31'h55555555,   1'b0},
        '{OP_INSERT, 31'd1,          1'b0, 31'd0,          1'b0},
        '{OP_INSERT, 31'h7FFFFFFE,   1'b0, 31'd0,          1'b0},
        '{OP_INSERT, 31'h7FFFFFFF,   1'b0, 31'd0,          1'b0},
        '{OP_INSERT, 31'h7FFFFFFF,   1'b0, 31'd0,          1'b0},
        '{OP_FLUSH,  31'd0,          1'b1, 31'h7FFFFFFF,   1'b0}
    };

    systolic_insertion_sorter uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_res (m_value_res),
        .m_empty_res (m_empty_res),
        .m_last      (m_last)
    );

    always #2 aclk = ~aclk;

    function automatic void store_clear();
        for (int j = 0; j < CAPACITY; j++) begin
            sorted_val[j]  = '0;
            sorted_full[j] = 1'b0;
        end
        fill_count = 0;
    endfunction

    function automatic void store_insert(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] carry;
        logic [VALUE_W-1:0] held;
        carry = v;
        fill_count++;
        for (int j = 0; j < CAPACITY; j++) begin
            if (!sorted_full[j]) begin
                sorted_val[j]  = carry;
                sorted_full[j] = 1'b1;
                return;
            end
            if (carry > sorted_val[j]) begin
                held          = sorted_val[j];
                sorted_val[j] = carry;
                carry         = held;
            end
        end
    endfunction

    function automatic void store_flush();
        rank_beat_t b;
        if (fill_count > CAPACITY)
            overfill_count++;
        for (int k = 0; k < CAPACITY; k++) begin
            b.value = sorted_full[k] ? sorted_val[k] : '0;
            b.empty = !sorted_full[k];
            b.last  = (k == CAPACITY - 1);
            pending_ranks.push_back(b);
        end
        store_clear();
    endfunction

    // after a random idle gap between bursts, drive one beat, wait for it to be taken, then update the predicted store
    task automatic issue_item(input op_t op, input logic [VALUE_W-1:0] v, output int first_idx);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        first_idx = pending_ranks.size();
        if (op == OP_FLUSH) begin
            flush_count++;
            store_flush();
        end else begin
            insert_count++;
            store_insert(v);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input int vmode);
        logic [VALUE_W-1:0] v;
        case (vmode)
            0: v = VALUE_W'($urandom());
            1: v = VALUE_W'($urandom_range(0, 15));
            default: begin
                if ($urandom_range(0, 1) == 0)
                    v = VALUE_W'($urandom_range(0, 3));
                else
                    v = 31'h7FFFFFFF - VALUE_W'($urandom_range(0, 3));
            end
        endcase
        return v;
    endfunction

    // receiver: scoreboard and stall pattern
    always @(posedge aclk) begin
        rank_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (pending_ranks.size() == 0) begin
                $error("result beat with nothing expected: value_res %0d empty_res %0d last %0d",
                       m_value_res, m_empty_res, m_last);
                err_count++;
            end else begin
                exp_beat = pending_ranks.pop_front();
                beats_checked++;
                if (m_value_res !== exp_beat.value) begin
                    $error("value_res mismatch: expected %0d, got %0d",
                           exp_beat.value, m_value_res);
                    err_count++;
                end
                if (m_empty_res !== exp_beat.empty) begin
                    $error("empty_res mismatch: expected %0d, got %0d",
                           exp_beat.empty, m_empty_res);
                    err_count++;
                end
                if (m_last !== exp_beat.last) begin
                    $error("last mismatch: expected %0d, got %0d", exp_beat.last, m_last);
                    err_count++;
                end
            end
        end
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
            default:   m_ready <= (rx_left % 8 == 0);
        endcase
    end

    // watchdog: end the run if neither channel moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_ranks.size());
        $display("FAILURE");
        $finish;
    end

    initial begin
        int idx;
        int seq_len;
        int vmode;
        int sent;
        store_clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            issue_item(dir_rows[r].op, dir_rows[r].value, idx);
            if (dir_rows[r].typed) begin
                pending_ranks[idx].value = dir_rows[r].top_value;
                pending_ranks[idx].empty = dir_rows[r].top_empty;
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       seq_len = $urandom_range(0, 3);
                1:       seq_len = $urandom_range(CAPACITY, CAPACITY + 40);
                default: seq_len = $urandom_range(1, CAPACITY - 1);
            endcase
            vmode = $urandom_range(0, 3);
            repeat (seq_len) begin
                issue_item(OP_INSERT, pick_value(vmode), idx);
                sent++;
            end
            issue_item(OP_FLUSH, pick_value(0), idx);
            sent++;
        end

        s_valid <= 1'b0;
        while (pending_ranks.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d inserts and %0d flushes, %0d of them on an overfilled store.",
                 insert_count, flush_count, overfill_count);
        $display("Checked %0d result beats with %0d mismatches.", beats_checked, err_count);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
